// ===== src/pcmf_pkg.sv =====
package pcmf_pkg;

  // Pixel array geometry
  localparam int NUM_COLS  = 128;
  localparam int NUM_ROWS  = 512;
  localparam int MASK_BITS = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W    = $clog2(MASK_BITS);

  // Queue between classification and the cluster/event sequencer
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register map
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y = 8'd1;
  localparam logic [15:0] PITCH_X_RST = 16'd800;
  localparam logic [15:0] PITCH_Y_RST = 16'd4000;

  // Item function codes
  localparam logic FUNC_MASK_WR = 1'b0;
  localparam logic FUNC_HIT     = 1'b1;

  typedef struct packed {
    logic              func;
    logic [6:0]        col;
    logic [8:0]        row;
    logic              mask_set;
    logic signed [23:0] track_x;
    logic signed [23:0] track_y;
    logic              last_in_cluster;
    logic              last_in_event;
  } in_item_t;

  typedef struct packed {
    logic cluster_keep;
    logic event_done;
    logic track_bad;
  } out_item_t;

  // Classified hit, as handed to the sequencer
  typedef struct packed {
    logic masked;
    logic matched;
    logic ends_cluster;
    logic ends_event;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

endpackage

// ===== src/pcmf_front.sv =====
module pcmf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcmf_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [pcmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic [pcmf_pkg::Q_CNT_W-1:0]        q_count,
  output pcmf_pkg::q_push_t                   q_push
);

  logic [15:0] pitch_x_r;
  logic [15:0] pitch_y_r;

  // Mask store and its clearing pass
  logic                        mask_mem [pcmf_pkg::MASK_BITS];
  logic [pcmf_pkg::ADDR_W-1:0] clr_idx_r;
  logic                        clr_busy_r;

  // Stage A: mask read data and products
  logic               a_valid_r;
  logic               a_mask_r;
  logic               a_inside_r;
  logic [22:0]        a_prod_x_r;
  logic [24:0]        a_prod_y_r;
  logic signed [23:0] a_tx_r;
  logic signed [23:0] a_ty_r;
  logic               a_lic_r;
  logic               a_lie_r;

  logic                        in_acc;
  logic                        in_array;
  logic [pcmf_pkg::ADDR_W-1:0] addr;
  logic                        wr_en;
  logic [pcmf_pkg::ADDR_W-1:0] wr_addr;
  logic                        wr_bit;
  logic [pcmf_pkg::Q_CNT_W:0]  q_need;

  logic signed [27:0] dx;
  logic signed [27:0] dy;
  logic [27:0]        ax;
  logic [27:0]        ay;
  logic               near_x;
  logic               near_y;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_x_r <= pcmf_pkg::PITCH_X_RST;
      pitch_y_r <= pcmf_pkg::PITCH_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pcmf_pkg::CFG_PITCH_X) pitch_x_r <= cfg_data;
      if (cfg_index == pcmf_pkg::CFG_PITCH_Y) pitch_y_r <= cfg_data;
    end
  end

  // Hold off input while clearing, or when the queue could overflow
  assign q_need   = {1'b0, q_count} + {{pcmf_pkg::Q_CNT_W{1'b0}}, a_valid_r};
  assign in_stall = clr_busy_r || (q_need >= (pcmf_pkg::Q_CNT_W+1)'(pcmf_pkg::Q_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  assign in_array = (32'(in_data.col) < 32'(pcmf_pkg::NUM_COLS)) &&
                    (32'(in_data.row) < 32'(pcmf_pkg::NUM_ROWS));
  assign addr     = pcmf_pkg::ADDR_W'(32'(in_data.col) * 32'(pcmf_pkg::NUM_ROWS) +
                                      32'(in_data.row));

  // Clearing pass after reset, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == pcmf_pkg::ADDR_W'(pcmf_pkg::MASK_BITS - 1)) clr_busy_r <= 1'b0;
    end
  end

  // Single write port: clear pass or mask-write transaction
  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_bit  = 1'b0;
    end else begin
      wr_en   = in_acc && (in_data.func == pcmf_pkg::FUNC_MASK_WR) && in_array;
      wr_addr = addr;
      wr_bit  = in_data.mask_set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mask_mem[wr_addr] <= wr_bit;
  end

  always_ff @(posedge clk) begin
    a_mask_r <= mask_mem[addr];
  end

  // Stage A register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_acc && (in_data.func == pcmf_pkg::FUNC_HIT);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_inside_r <= in_array;
      a_prod_x_r <= 23'(pitch_x_r) * 23'(in_data.col);
      a_prod_y_r <= 25'(pitch_y_r) * 25'(in_data.row);
      a_tx_r     <= in_data.track_x;
      a_ty_r     <= in_data.track_y;
      a_lic_r    <= in_data.last_in_cluster;
      a_lie_r    <= in_data.last_in_event;
    end
  end

  // Track window: 2*|t - p*idx| < 3*p on each axis
  always_comb begin
    dx = 28'(a_tx_r) - $signed({5'b0, a_prod_x_r});
    dy = 28'(a_ty_r) - $signed({3'b0, a_prod_y_r});
    ax = dx[27] ? 28'(-dx) : 28'(dx);
    ay = dy[27] ? 28'(-dy) : 28'(dy);
    near_x = {ax[26:0], 1'b0} < (28'({pitch_x_r, 1'b0}) + 28'(pitch_x_r));
    near_y = {ay[26:0], 1'b0} < (28'({pitch_y_r, 1'b0}) + 28'(pitch_y_r));
  end

  always_comb begin
    q_push.push               = a_valid_r;
    q_push.entry.masked       = a_inside_r && a_mask_r;
    q_push.entry.matched      = near_x && near_y;
    q_push.entry.ends_cluster = a_lic_r;
    q_push.entry.ends_event   = a_lie_r;
  end

endmodule

// ===== src/pcmf_fifo.sv =====
module pcmf_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcmf_pkg::q_push_t             q_push,
  input  logic                          q_pop,
  output pcmf_pkg::q_entry_t            q_head,
  output logic                          q_empty,
  output logic [pcmf_pkg::Q_CNT_W-1:0]  q_count
);

  pcmf_pkg::q_entry_t            slot_r [pcmf_pkg::Q_DEPTH];
  logic [pcmf_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [pcmf_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [pcmf_pkg::Q_CNT_W-1:0]  cnt_r;

  logic do_push;
  logic do_pop;

  // Upstream guarantees space for every push
  assign do_push = q_push.push;
  assign do_pop  = q_pop && (cnt_r != '0);

  assign q_head  = slot_r[rd_ptr_r];
  assign q_empty = (cnt_r == '0);
  assign q_count = cnt_r;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= q_push.entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/pcmf_back.sv =====
module pcmf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcmf_pkg::q_entry_t   q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcmf_pkg::out_item_t  out_data
);

  logic                cl_masked_r,  cl_masked_nxt;
  logic                cl_matched_r, cl_matched_nxt;
  logic                ev_bad_r,     ev_bad_nxt;
  logic                out_valid_r,  out_valid_nxt;
  pcmf_pkg::out_item_t out_data_r,   out_data_nxt;

  logic masked;
  logic matched;
  logic ends;
  logic bad;
  logic slot_free;

  // Cluster/event bookkeeping: an entry/cycle unless stalled
  always_comb begin
    masked    = cl_masked_r | q_head.masked;
    matched   = cl_matched_r | q_head.matched;
    ends      = q_head.ends_cluster | q_head.ends_event;
    bad       = ev_bad_r | (masked & matched);
    slot_free = !out_valid_r || !out_stall;
    q_pop     = !q_empty && (!ends || slot_free);

    cl_masked_nxt  = cl_masked_r;
    cl_matched_nxt = cl_matched_r;
    ev_bad_nxt     = ev_bad_r;
    out_valid_nxt  = slot_free ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;

    if (q_pop) begin
      if (ends) begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.cluster_keep = !masked;
        out_data_nxt.event_done   = q_head.ends_event;
        out_data_nxt.track_bad    = q_head.ends_event && bad;
        cl_masked_nxt  = 1'b0;
        cl_matched_nxt = 1'b0;
        ev_bad_nxt     = q_head.ends_event ? 1'b0 : bad;
      end else begin
        cl_masked_nxt  = masked;
        cl_matched_nxt = matched;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_masked_r  <= 1'b0;
      cl_matched_r <= 1'b0;
      ev_bad_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cl_masked_r  <= cl_masked_nxt;
      cl_matched_r <= cl_matched_nxt;
      ev_bad_r     <= ev_bad_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/pixel_cluster_mask_filter_unit.sv =====
// out_valid rises once a hit that ends a cluster or an event has passed the stage register and the queue.
// Throughput: one item per cycle while in_stall is low, set by the single mask-store port
// (one access per item).
// Mask writes and hits that end neither a cluster nor an event produce no result.
// Reset (synchronous, rst_n low) clears cluster/event state, restores the pitches, and
// starts a clearing pass over all NUM_COLS*NUM_ROWS (65536) bits of the mask store;
// in_stall stays high during the pass while configuration writes are still taken.
module pixel_cluster_mask_filter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pcmf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pcmf_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  pcmf_pkg::q_push_t             q_push;
  pcmf_pkg::q_entry_t            q_head;
  logic                          q_empty;
  logic                          q_pop;
  logic [pcmf_pkg::Q_CNT_W-1:0]  q_count;

  assign cfg_ready = 1'b1;

  // Accept, mask store and classification
  pcmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .q_push    (q_push)
  );

  // Decoupling queue
  pcmf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_count (q_count)
  );

  // Cluster/event sequencer and output register
  pcmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/pcmf_checker.sv =====
module pcmf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pcmf_pkg::out_item_t out_data
);

  // A stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Track flag only on an event-closing result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.track_bad |-> out_data.event_done)
    else $error("track_bad without event_done");

  // Mask clearing pass blocks input right after reset
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open during mask clear");

  // Nothing is emitted in the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind pixel_cluster_mask_filter_unit pcmf_checker u_pcmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
